// ===== rtl/chk_pkg.sv =====
package chk_pkg;

  localparam int BUCKETS       = 1024;
  localparam int NODES         = 1024;
  localparam int MAX_KEY_BYTES = 8;

  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int NODE_W   = $clog2(NODES);
  localparam int LINK_W   = $clog2(NODES + 1);
  localparam int CNT_W    = $clog2(NODES + 1);
  localparam int HASH_W   = 16;

  localparam logic [LINK_W-1:0] NULL_LINK  = LINK_W'(NODES);
  localparam logic [HASH_W-1:0] HASH_START = HASH_W'(5381);
  localparam logic [3:0]        KB_RESET   = 4'd8;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_DEL   = 2'd1;
  localparam logic [1:0] CMD_TEST  = 2'd2;
  // unused code, handled as a membership test
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
  } in_t;

  typedef struct packed {
    logic        success;
    logic [1:0]  status;
    logic [10:0] entry_total;
  } out_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic [1:0]          cmd;
    logic [63:0]         key;
    logic [63:0]         mask;
    logic [BUCKET_W-1:0] bucket;
  } job_t;

endpackage

// ===== rtl/chk_ram.sv =====
module chk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/chk_queue.sv =====
module chk_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  chk_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output chk_pkg::job_t head
);
  import chk_pkg::*;

  job_t       slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = slot_r[rptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ pop;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/chk_front.sv =====
module chk_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  chk_pkg::in_t  in_item,
  input  logic          cfg_valid,
  input  logic [3:0]    cfg_data,
  output logic          push,
  output chk_pkg::job_t push_job
);
  import chk_pkg::*;

  logic [3:0]        kb_r;
  logic [3:0]        n;
  logic [HASH_W-1:0] h;
  logic [HASH_W-1:0] b_ext;
  logic [63:0]       mask;
  logic [7:0]        byte_v;

  // key length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kb_r <= KB_RESET;
    end else if (cfg_valid) begin
      kb_r <= cfg_data;
    end
  end

  // clamp length, hash selected bytes, build compare mask
  always_comb begin
    n = kb_r;
    if (n == 4'd0) n = 4'd1;
    if (n > 4'(MAX_KEY_BYTES)) n = 4'(MAX_KEY_BYTES);
    h     = HASH_START;
    mask  = '0;
    b_ext = '0;
    byte_v = '0;
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      byte_v = in_item.key[8*i +: 8];
      b_ext  = {{(HASH_W-8){byte_v[7]}}, byte_v};
      if (4'(i) < n) begin
        h = (h << 5) + h + b_ext;
        mask[8*i +: 8] = 8'hFF;
      end
    end
  end

  assign push            = start && !busy;
  assign push_job.cmd    = in_item.cmd;
  assign push_job.key    = in_item.key;
  assign push_job.mask   = mask;
  assign push_job.bucket = h[BUCKET_W-1:0];

endmodule

// ===== rtl/chk_back.sv =====
module chk_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  chk_pkg::job_t q_head,
  output logic          pop,
  output logic          clearing,
  output logic          res_valid,
  output chk_pkg::out_t res
);
  import chk_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HEAD, S_NODE, S_EXEC, S_LINK
  } state_t;

  state_t              state_r, state_nxt;
  job_t                job_r, job_nxt;
  logic [LINK_W-1:0]   cur_r, cur_nxt;
  logic [LINK_W-1:0]   prev_r, prev_nxt;
  logic [LINK_W-1:0]   nx_r, nx_nxt;
  logic [NODE_W-1:0]   nd_r, nd_nxt;
  logic                found_r, found_nxt;
  logic [CNT_W-1:0]    live_r, live_nxt;
  logic [CNT_W-1:0]    sp_r, sp_nxt;
  logic [CNT_W-1:0]    fresh_r, fresh_nxt;
  logic [BUCKET_W-1:0] clr_r, clr_nxt;
  logic                res_valid_r, res_valid_nxt;
  out_t                res_r, res_nxt;

  logic                head_we;
  logic [BUCKET_W-1:0] head_waddr, head_raddr;
  logic [LINK_W-1:0]   head_wdata, head_rd;
  logic                key_we;
  logic [NODE_W-1:0]   key_waddr, node_raddr;
  logic [63:0]         key_rd;
  logic                link_we;
  logic [NODE_W-1:0]   link_waddr;
  logic [LINK_W-1:0]   link_wdata, link_rd;
  logic                stk_we;
  logic [NODE_W-1:0]   stk_waddr, stk_raddr;
  logic [NODE_W-1:0]   stk_rd;
  logic [NODE_W-1:0]   nd;
  logic [CNT_W-1:0]    sp_dec;
  logic                match;

  chk_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_heads (
    .clk, .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rd)
  );
  chk_ram #(.WIDTH(64), .DEPTH(NODES)) u_keys (
    .clk, .we(key_we), .waddr(key_waddr), .wdata(job_r.key),
    .raddr(node_raddr), .rdata(key_rd)
  );
  chk_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_links (
    .clk, .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(node_raddr), .rdata(link_rd)
  );
  chk_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_free (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(cur_r[NODE_W-1:0]),
    .raddr(stk_raddr), .rdata(stk_rd)
  );

  assign clearing  = (state_r == S_CLEAR);
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign match     = ((key_rd ^ job_r.key) & job_r.mask) == 64'd0;
  assign sp_dec    = sp_r - CNT_W'(1);
  assign stk_raddr = sp_dec[NODE_W-1:0];
  assign stk_waddr = sp_r[NODE_W-1:0];
  assign nd        = (sp_r != '0) ? stk_rd : fresh_r[NODE_W-1:0];
  assign head_raddr = (state_r == S_IDLE) ? q_head.bucket : job_r.bucket;
  assign node_raddr = (state_r == S_HEAD) ? head_rd[NODE_W-1:0] : link_rd[NODE_W-1:0];

  // chain walk and update sequencer
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    nx_nxt        = nx_r;
    nd_nxt        = nd_r;
    found_nxt     = found_r;
    live_nxt      = live_r;
    sp_nxt        = sp_r;
    fresh_nxt     = fresh_r;
    clr_nxt       = clr_r;
    res_valid_nxt = 1'b0;
    res_nxt       = res_r;
    pop           = 1'b0;
    head_we       = 1'b0;
    head_waddr    = job_r.bucket;
    head_wdata    = NULL_LINK;
    key_we        = 1'b0;
    key_waddr     = nd;
    link_we       = 1'b0;
    link_waddr    = nd;
    link_wdata    = NULL_LINK;
    stk_we        = 1'b0;
    case (state_r)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
        clr_nxt    = clr_r + BUCKET_W'(1);
        if (clr_r == BUCKET_W'(BUCKETS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          job_nxt   = q_head;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        cur_nxt   = head_rd;
        prev_nxt  = NULL_LINK;
        found_nxt = 1'b0;
        state_nxt = (head_rd >= NULL_LINK) ? S_EXEC : S_NODE;
      end
      S_NODE: begin
        if (match) begin
          found_nxt = 1'b1;
          nx_nxt    = link_rd;
          state_nxt = S_EXEC;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = link_rd;
          if (link_rd >= NULL_LINK) state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        res_nxt.success = found_r;
        res_nxt.status  = found_r ? ST_DONE : ST_ABSENT;
        case (job_r.cmd)
          CMD_ADD: begin
            res_nxt.success = 1'b0;
            if (found_r) begin
              res_nxt.status = ST_PRESENT;
            end else if (live_r == CNT_W'(NODES)) begin
              res_nxt.status = ST_FULL;
            end else begin
              key_we  = 1'b1;
              link_we = 1'b1;
              if (sp_r != '0) sp_nxt = sp_dec;
              else fresh_nxt = fresh_r + CNT_W'(1);
              if (prev_r >= NULL_LINK) begin
                head_we    = 1'b1;
                head_wdata = LINK_W'(nd);
              end else begin
                nd_nxt    = nd;
                state_nxt = S_LINK;
              end
              live_nxt        = live_r + CNT_W'(1);
              res_nxt.success = 1'b1;
              res_nxt.status  = ST_DONE;
            end
          end
          CMD_DEL: begin
            if (found_r) begin
              if (prev_r >= NULL_LINK) begin
                head_we    = 1'b1;
                head_wdata = nx_r;
              end else begin
                link_we    = 1'b1;
                link_waddr = prev_r[NODE_W-1:0];
                link_wdata = nx_r;
              end
              stk_we   = 1'b1;
              sp_nxt   = sp_r + CNT_W'(1);
              live_nxt = live_r - CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
        res_nxt.entry_total = 11'(live_nxt);
      end
      S_LINK: begin
        link_we    = 1'b1;
        link_waddr = prev_r[NODE_W-1:0];
        link_wdata = LINK_W'(nd_r);
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      live_r      <= '0;
      sp_r        <= '0;
      fresh_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      live_r      <= live_nxt;
      sp_r        <= sp_nxt;
      fresh_r     <= fresh_nxt;
      res_valid_r <= res_valid_nxt;
    end
    job_r   <= job_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    nx_r    <= nx_nxt;
    nd_r    <= nd_nxt;
    found_r <= found_nxt;
    res_r   <= res_nxt;
  end

endmodule

// ===== rtl/chained_hash_key_set.sv =====
// operation flow: the queue hands each start to the walker, which reads the bucket head and then
// visits one chain node per step; an add that links behind a tail node holds the walker in S_LINK
// operations run one at a time through the chain walk over the
// single read port of the node memories; a two-beat queue takes starts meanwhile
// reset: synchronous active-low rst_n; afterwards busy stays high while the bucket heads are
// cleared; results are strobed for one cycle and cannot be stalled
module chained_hash_key_set (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  chk_pkg::in_t  in_item,
  output logic          out_valid,
  output chk_pkg::out_t out_item,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [3:0]    cfg_data
);
  import chk_pkg::*;

  logic push, pop, q_full, q_empty, clearing;
  job_t push_job, q_head;

  assign busy      = q_full || clearing;
  assign cfg_ready = 1'b1;

  chk_front u_front (
    .clk, .rst_n, .start, .busy, .in_item,
    .cfg_valid(cfg_valid && cfg_ready), .cfg_data,
    .push, .push_job
  );

  chk_queue u_queue (
    .clk, .rst_n, .push, .push_job, .pop,
    .full(q_full), .empty(q_empty), .head(q_head)
  );

  chk_back u_back (
    .clk, .rst_n, .q_empty, .q_head, .pop, .clearing,
    .res_valid(out_valid), .res(out_item)
  );

endmodule

// ===== dv/chained_hash_key_set_chk.sv =====
module chained_hash_key_set_chk
  import chk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_t        in_item,
  input  logic       out_valid,
  input  out_t       out_item,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [3:0] cfg_data,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the key set
  logic [LINK_W-1:0] head_tbl [BUCKETS];
  logic [63:0]       node_key [NODES];
  logic [LINK_W-1:0] node_nxt [NODES];
  logic [LINK_W-1:0] free_stk [NODES];
  int                free_cnt;
  int                held;
  logic [3:0]        kb_setting;
  out_t              owed [$];

  // djb2 over the selected bytes, bytes taken as signed
  function automatic int unsigned bucket_for(logic [63:0] key, int nb);
    logic [63:0] h;
    logic [63:0] b;
    h = 64'd5381;
    for (int i = 0; i < nb; i++) begin
      b = {{56{key[8*i+7]}}, key[8*i +: 8]};
      h = (h << 5) + h + b;
    end
    return int'(h & 64'(BUCKETS - 1));
  endfunction

  // apply one operation to the shadow set and return its outcome
  function automatic out_t set_apply(in_t it);
    int nb;
    logic [63:0] msk;
    int unsigned bkt;
    int cur;
    int prv;
    int steps;
    int nd;
    bit hit;
    out_t r;
    nb = (kb_setting == 0) ? 1 : (kb_setting > MAX_KEY_BYTES) ? MAX_KEY_BYTES : kb_setting;
    msk = (nb >= 8) ? '1 : ((64'd1 << (8 * nb)) - 64'd1);
    bkt = bucket_for(it.key, nb);
    cur = head_tbl[bkt];
    prv = NODES;
    steps = 0;
    hit = 0;
    r = '0;
    r.status = ST_ABSENT;
    while (cur < NODES && steps <= NODES) begin
      if (((node_key[cur] ^ it.key) & msk) == 0) begin
        hit = 1;
        break;
      end
      prv = cur;
      cur = node_nxt[cur];
      steps++;
    end
    if (it.cmd == CMD_ADD) begin
      if (hit) r.status = ST_PRESENT;
      else if (free_cnt == 0) r.status = ST_FULL;
      else begin
        free_cnt--;
        nd = free_stk[free_cnt];
        node_key[nd] = it.key;
        node_nxt[nd] = NULL_LINK;
        if (prv < NODES) node_nxt[prv] = LINK_W'(nd);
        else head_tbl[bkt] = LINK_W'(nd);
        held++;
        r.success = 1;
        r.status = ST_DONE;
      end
    end else if (it.cmd == CMD_DEL) begin
      if (hit) begin
        if (prv < NODES) node_nxt[prv] = node_nxt[cur];
        else head_tbl[bkt] = node_nxt[cur];
        free_stk[free_cnt] = LINK_W'(cur);
        free_cnt++;
        if (held > 0) held--;
        r.success = 1;
        r.status = ST_DONE;
      end
    end else if (hit) begin
      r.success = 1;
      r.status = ST_DONE;
    end
    r.entry_total = 11'(held);
    return r;
  endfunction

  // watch the three channels
  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < BUCKETS; i++) head_tbl[i] = NULL_LINK;
      for (int i = 0; i < NODES; i++) free_stk[i] = LINK_W'(NODES - 1 - i);
      free_cnt = NODES;
      held = 0;
      kb_setting = KB_RESET;
      owed.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (owed.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          exp_r = owed.pop_front();
          if (out_item.success !== exp_r.success) begin
            $error("success exp %0d got %0d", exp_r.success, out_item.success);
            fail_count++;
          end
          if (out_item.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, out_item.status);
            fail_count++;
          end
          if (out_item.entry_total !== exp_r.entry_total) begin
            $error("entry_total exp %0d got %0d", exp_r.entry_total, out_item.entry_total);
            fail_count++;
          end
        end
      end
      if (start && !busy) owed.push_back(set_apply(in_item));
      if (cfg_valid && cfg_ready) kb_setting = cfg_data;
    end
    pending = owed.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end
endmodule

// ===== dv/chained_hash_key_set_tb.sv =====
module chained_hash_key_set_tb;
  import chk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_t        in_item;
  logic       out_valid;
  out_t       out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;
  int         fail_count;
  int         pending;
  int         burst_left;
  int         quiet;
  logic [63:0] recent [$];

  chained_hash_key_set DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  chained_hash_key_set_chk u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // one operation beat, with bursts and random gaps in front
  task automatic send_op(logic [1:0] cmd, logic [63:0] key);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        start <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1;
    in_item <= '{cmd: cmd, key: key};
    do @(posedge clk); while (busy);
    if (recent.size() < 64) recent.push_back(key);
    else recent[$urandom_range(0, 63)] = key;
  endtask

  // register write once all results are back
  task automatic set_key_bytes(logic [3:0] v);
    start <= 0;
    burst_left = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  // reuse a recent key, sometimes with its high bits 63:16 scrambled (unused at two key bytes or fewer)
  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    if (recent.size() == 0 || $urandom_range(0, 2) == 0) return {$urandom(), $urandom()};
    k = recent[$urandom_range(0, recent.size() - 1)];
    if ($urandom_range(0, 3) == 0) k[63:16] = 48'({$urandom(), $urandom()});
    return k;
  endfunction

  task automatic random_ops(int count);
    int r;
    logic [1:0] c;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      c = (r < 45) ? CMD_ADD : (r < 70) ? CMD_DEL : (r < 95) ? CMD_TEST : CMD_SPARE;
      send_op(c, pick_key());
    end
  endtask

  // idle watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("chained_hash_key_set verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    start = 0;
    in_item = '0;
    cfg_valid = 0;
    cfg_data = '0;
    quiet = 0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, duplicates, absent keys, sign bytes, unused cmd
    send_op(CMD_TEST, 64'd0);
    send_op(CMD_ADD, 64'd0);
    send_op(CMD_ADD, '1);
    send_op(CMD_ADD, '1);
    send_op(CMD_TEST, '1);
    send_op(CMD_SPARE, 64'd0);
    send_op(CMD_ADD, 64'h80);
    send_op(CMD_ADD, 64'h7f7f_7f7f_7f7f_7f7f);
    send_op(CMD_DEL, 64'h80);
    send_op(CMD_DEL, 64'h80);
    send_op(CMD_DEL, 64'hdead_beef);
    send_op(CMD_ADD, 64'h8000_0000_0000_0000);
    send_op(CMD_TEST, 64'h8000_0000_0000_0000);
    set_key_bytes(4'd1);
    // only low byte compared: same key with different upper bits
    send_op(CMD_ADD, 64'h1234_5678_9abc_de11);
    send_op(CMD_ADD, 64'hffff_0000_0000_0011);
    send_op(CMD_TEST, 64'h0000_0000_0000_0011);
    send_op(CMD_DEL, 64'haaaa_aaaa_aaaa_aa11);
    send_op(CMD_TEST, 64'hff);
    set_key_bytes(4'd0);
    send_op(CMD_ADD, 64'h5500);
    send_op(CMD_TEST, 64'h7700);
    set_key_bytes(4'd15);
    send_op(CMD_TEST, '1);
    send_op(CMD_DEL, '1);

    // random phases across settings
    set_key_bytes(4'd1);
    random_ops(60);
    set_key_bytes(4'd3);
    random_ops(60);
    set_key_bytes(4'd0);
    random_ops(60);
    set_key_bytes(4'd8);
    random_ops(60);
    set_key_bytes(4'd2);
    random_ops(60);
    set_key_bytes(4'd6);
    random_ops(60);

    // load many keys for longer chains, then drain part of them
    set_key_bytes(4'd4);
    for (int i = 0; i < 400; i++) send_op(CMD_ADD, {$urandom(), $urandom()});
    random_ops(60);
    for (int i = 0; i < 40; i++) send_op(CMD_DEL, pick_key());
    set_key_bytes(4'd15);
    random_ops(20);

    start <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("chained_hash_key_set verification clean");
    else $display("chained_hash_key_set verification failed");
    $finish;
  end
endmodule

// ===== chained_hash_key_set.f =====
rtl/chk_pkg.sv
rtl/chk_ram.sv
rtl/chk_queue.sv
rtl/chk_front.sv
rtl/chk_back.sv
rtl/chained_hash_key_set.sv
dv/chained_hash_key_set_chk.sv
dv/chained_hash_key_set_tb.sv
